>>> hw/rtl/pe2x_pkg.sv
// ----------------------------------------------------------------------------
// pe2x_pkg: shared types and constants
// Register indexes, state encodings and the block job passed front to back.
// ----------------------------------------------------------------------------
package pe2x_pkg;

    localparam int PIX_W = 8;
    localparam int DIM_W = 11;
    localparam int TAP_W = 10;
    localparam int HSUM_W = 20;
    localparam int ACC_W = 32;

    // register indexes of the configuration port
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TAP0   = 3'd2;
    localparam logic [2:0] REG_TAP1   = 3'd3;
    localparam logic [2:0] REG_TAP2   = 3'd4;
    localparam logic [2:0] REG_TAP3   = 3'd5;
    localparam logic [2:0] REG_TAP4   = 3'd6;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_BLK1,
        F_BLK2
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_H,
        BK_O
    } back_state_t;

    // effective configuration
    typedef struct packed {
        logic [DIM_W-1:0]           width;
        logic [DIM_W-1:0]           height;
        logic [4:0][TAP_W-1:0]      tap;
    } cfg_t;

    // one 2x2 output block: source columns x-1, x, x+1 for three rows
    typedef struct packed {
        logic [2:0][PIX_W-1:0] a;
        logic [2:0][PIX_W-1:0] b;
        logic [2:0][PIX_W-1:0] d;
        logic [DIM_W-1:0]      x;
        logic [DIM_W-1:0]      row;
        logic                  last;
    } job_t;

endpackage

>>> hw/rtl/pe2x_ram.sv
// ----------------------------------------------------------------------------
// pe2x_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pe2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/pe2x_front.sv
// ----------------------------------------------------------------------------
// pe2x_front: item intake
// Tracks row and column, keeps two source rows and the column window, and
// hands up to two block jobs per item on to the job queue.
// ----------------------------------------------------------------------------
module pe2x_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pe2x_pkg::cfg_t               cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [pe2x_pkg::PIX_W-1:0]   s_pixel,
    output logic                         job_valid,
    input  logic                         job_ready,
    output pe2x_pkg::job_t               job
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = pe2x_pkg::PIX_W;
    localparam int DW = pe2x_pkg::DIM_W;

    pe2x_pkg::front_state_t st_reg, st_next;

    logic [AW-1:0]       col_reg, col_next;
    logic [DW-1:0]       row_reg, row_next;
    logic [2:0][1:0][PW-1:0] hist_reg, hist_next;

    logic                func_reg;
    logic [PW-1:0]       pix_reg;
    logic [AW-1:0]       idx_reg;
    logic [DW-1:0]       r_reg;
    logic                last_reg;
    logic                has1_reg, has2_reg;
    logic [2:0][PW-1:0]  ja_reg, jb_reg, jc_reg;

    logic                accept;
    logic [DW-1:0]       r_eff;
    logic                last_c;
    logic [AW-1:0]       idx_c;
    logic [PW-1:0]       old_rd, new_rd;
    logic [2:0][PW-1:0]  cur, a_c, b_c;
    logic                c_zero;

    assign s_ready = (st_reg == pe2x_pkg::F_IDLE);
    assign accept  = s_valid && s_ready;

    // position of the incoming item
    always_comb begin
        r_eff  = (row_reg > cfg.height) ? cfg.height : row_reg;
        last_c = (32'(col_reg) >= 32'(cfg.width) - 32'd1);
        idx_c  = last_c ? AW'(cfg.width - DW'(1)) : col_reg;
    end

    pe2x_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
        .aclk(aclk), .we(st_reg == pe2x_pkg::F_READ), .waddr(idx_reg), .wdata(cur[1]),
        .re(accept), .raddr(idx_c), .rdata(old_rd)
    );

    pe2x_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk(aclk), .we(st_reg == pe2x_pkg::F_READ), .waddr(idx_reg), .wdata(cur[2]),
        .re(accept), .raddr(idx_c), .rdata(new_rd)
    );

    // current column and window
    always_comb begin
        cur[0] = (r_reg >= DW'(2)) ? old_rd : '0;
        cur[1] = (r_reg >= DW'(1)) ? new_rd : '0;
        cur[2] = func_reg ? '0 : pix_reg;
        c_zero = (idx_reg == '0);
        for (int i = 0; i < 3; i++) begin
            a_c[i] = c_zero ? '0 : hist_reg[i][0];
            b_c[i] = c_zero ? '0 : hist_reg[i][1];
        end
    end

    // state and counters
    always_comb begin
        st_next   = st_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        hist_next = hist_reg;
        job_valid = 1'b0;
        job       = '0;
        unique case (st_reg)
            pe2x_pkg::F_IDLE: begin
                if (accept) st_next = pe2x_pkg::F_READ;
            end
            pe2x_pkg::F_READ: begin
                for (int i = 0; i < 3; i++) begin
                    hist_next[i][0] = b_c[i];
                    hist_next[i][1] = cur[i];
                end
                if (last_reg) begin
                    col_next = '0;
                    row_next = (r_reg >= cfg.height) ? '0 : r_reg + DW'(1);
                end else begin
                    col_next = idx_reg + AW'(1);
                    row_next = r_reg;
                end
                st_next = pe2x_pkg::F_BLK1;
            end
            pe2x_pkg::F_BLK1: begin
                job.a    = ja_reg;
                job.b    = jb_reg;
                job.d    = jc_reg;
                job.x    = DW'(idx_reg) - DW'(1);
                job.row  = r_reg;
                job.last = !has2_reg;
                job_valid = has1_reg;
                if (!has1_reg || job_ready) st_next = pe2x_pkg::F_BLK2;
            end
            pe2x_pkg::F_BLK2: begin
                job.a    = jb_reg;
                job.b    = jc_reg;
                job.d    = '0;
                job.x    = DW'(idx_reg);
                job.row  = r_reg;
                job.last = 1'b1;
                job_valid = has2_reg;
                if (!has2_reg || job_ready) st_next = pe2x_pkg::F_IDLE;
            end
            default: st_next = pe2x_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= pe2x_pkg::F_IDLE;
            col_reg  <= '0;
            row_reg  <= '0;
            hist_reg <= '0;
        end else begin
            st_reg   <= st_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            hist_reg <= hist_next;
        end
    end

    // item capture and job fields
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            pix_reg  <= s_pixel;
            idx_reg  <= idx_c;
            r_reg    <= r_eff;
            last_reg <= last_c;
        end
        if (st_reg == pe2x_pkg::F_READ) begin
            ja_reg   <= a_c;
            jb_reg   <= b_c;
            jc_reg   <= cur;
            has1_reg <= (r_reg >= DW'(1)) && !c_zero;
            has2_reg <= (r_reg >= DW'(1)) && last_reg;
        end
    end

endmodule

>>> hw/rtl/pe2x_queue.sv
// ----------------------------------------------------------------------------
// pe2x_queue: two-entry job queue
// Decouples item intake from the arithmetic back end.
// ----------------------------------------------------------------------------
module pe2x_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  pe2x_pkg::job_t  push_job,
    output logic            pop_valid,
    input  logic            pop,
    output pe2x_pkg::job_t  head
);

    pe2x_pkg::job_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign head       = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (do_push) wptr_reg <= !wptr_reg;
            if (do_pop)  rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

>>> hw/rtl/pe2x_back.sv
// ----------------------------------------------------------------------------
// pe2x_back: block arithmetic
// Forms the horizontal sums row by row, then the four vertical sums, each
// rounded and saturated (zero on the border) into the output register.
// ----------------------------------------------------------------------------
module pe2x_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pe2x_pkg::cfg_t              cfg,
    input  logic                        job_valid,
    input  pe2x_pkg::job_t              job,
    output logic                        job_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pe2x_pkg::PIX_W-1:0]  m_value,
    output logic [pe2x_pkg::DIM_W-1:0]  m_out_row,
    output logic [pe2x_pkg::DIM_W-1:0]  m_out_col,
    output logic                        m_last_of_run,
    output logic                        m_frame_done
);

    localparam int DW = pe2x_pkg::DIM_W;
    localparam int HW = pe2x_pkg::HSUM_W;
    localparam int AC = pe2x_pkg::ACC_W;

    pe2x_pkg::back_state_t st_reg, st_next;
    logic [1:0] i_reg, i_next, k_reg, k_next;
    logic [2:0][HW-1:0] he_reg, ho_reg;

    logic           mv_reg;
    logic [7:0]     val_reg;
    logic [DW-1:0]  row_reg, col_reg;
    logic           lr_reg, fd_reg;

    logic           load;
    logic [HW-1:0]  he_c, ho_c;
    logic [2:0][HW-1:0] s;
    logic [2:0][pe2x_pkg::TAP_W-1:0] wt;
    logic [AC-1:0]  acc;
    logic [AC:0]    rnd;
    logic [7:0]     sat;
    logic [DW:0]    row_w, col_w, row_lim, col_lim;
    logic           border, corner;

    // horizontal sums for source row i
    always_comb begin
        he_c = HW'(cfg.tap[0] * job.a[i_reg]) + HW'(cfg.tap[2] * job.b[i_reg])
             + HW'(cfg.tap[4] * job.d[i_reg]);
        ho_c = HW'(cfg.tap[1] * job.b[i_reg]) + HW'(cfg.tap[3] * job.d[i_reg]);
    end

    // vertical sum for output k: bit 0 odd column, bit 1 odd row
    always_comb begin
        s = k_reg[0] ? ho_reg : he_reg;
        if (k_reg[1]) wt = {cfg.tap[3], cfg.tap[1], pe2x_pkg::TAP_W'(0)};
        else          wt = {cfg.tap[4], cfg.tap[2], cfg.tap[0]};
        acc = AC'(wt[0]) * AC'(s[0]) + AC'(wt[1]) * AC'(s[1]) + AC'(wt[2]) * AC'(s[2]);
        rnd = {1'b0, acc} + (AC+1)'(32768);
        sat = (rnd[AC:16] > (AC-15)'(255)) ? 8'hFF : rnd[23:16];
        row_w = {job.row, 1'b0} - (DW+1)'(2) + (DW+1)'(k_reg[1]);
        col_w = {job.x, 1'b0} + (DW+1)'(k_reg[0]);
        row_lim = {cfg.height, 1'b0} - (DW+1)'(1);
        col_lim = {cfg.width, 1'b0} - (DW+1)'(1);
        corner = (row_w == row_lim) && (col_w == col_lim);
        border = (row_w == '0) || (row_w == row_lim) || (col_w == '0) || (col_w == col_lim);
    end

    assign load = (st_reg == pe2x_pkg::BK_O) && (!mv_reg || m_ready);

    // sequencer
    always_comb begin
        st_next = st_reg;
        i_next  = i_reg;
        k_next  = k_reg;
        job_pop = 1'b0;
        unique case (st_reg)
            pe2x_pkg::BK_IDLE: begin
                i_next = 2'd0;
                if (job_valid) st_next = pe2x_pkg::BK_H;
            end
            pe2x_pkg::BK_H: begin
                i_next = i_reg + 2'd1;
                k_next = 2'd0;
                if (i_reg == 2'd2) st_next = pe2x_pkg::BK_O;
            end
            pe2x_pkg::BK_O: begin
                if (load) begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        job_pop = 1'b1;
                        st_next = pe2x_pkg::BK_IDLE;
                    end
                end
            end
            default: st_next = pe2x_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= pe2x_pkg::BK_IDLE;
            i_reg  <= 2'd0;
            k_reg  <= 2'd0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            i_reg  <= i_next;
            k_reg  <= k_next;
            if (load)         mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    // sum registers and output register
    always_ff @(posedge aclk) begin
        if (st_reg == pe2x_pkg::BK_H) begin
            he_reg[i_reg] <= he_c;
            ho_reg[i_reg] <= ho_c;
        end
        if (load) begin
            val_reg <= border ? 8'd0 : sat;
            row_reg <= row_w[DW-1:0];
            col_reg <= col_w[DW-1:0];
            lr_reg  <= job.last && (k_reg == 2'd3);
            fd_reg  <= corner;
        end
    end

    assign m_valid       = mv_reg;
    assign m_value       = val_reg;
    assign m_out_row     = row_reg;
    assign m_out_col     = col_reg;
    assign m_last_of_run = lr_reg;
    assign m_frame_done  = fd_reg;

endmodule

>>> hw/rtl/pyramid_expand_2x.sv
// ----------------------------------------------------------------------------
// pyramid_expand_2x: 2x image expansion with a separable 5-tap kernel
//
// Source pixels enter on the s_ channel in raster order (s_func = 0); after
// the last source row one row of drain items (s_func = 1) flushes the bottom
// output rows. Each item produces zero, four or eight output pixels on the
// m_ channel, 2x2 blocks one column behind, with row and column tags,
// last_of_run on the final pixel of the item and frame_done on the last
// pixel of the frame. Registers are written on the cfg_ channel (always
// ready); the user must write them only while the block is idle, which
// the block itself does not enforce. Intake steps each item through read
// and two job states before taking the next, and queues block jobs; the
// arithmetic back end works each 2x2 block in steps (1 job pickup, 3
// horizontal-sum steps, 4 output steps through one shared three-product
// vertical sum), picking up the next job only after the last output step.
// Reset clears counters, column window and queue; row stores need no clear.
// A stalled m_ready holds the output register and, once the two-entry job
// queue fills, stops intake.
// ----------------------------------------------------------------------------
module pyramid_expand_2x #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [pe2x_pkg::PIX_W-1:0]   s_pixel,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pe2x_pkg::PIX_W-1:0]   m_value,
    output logic [pe2x_pkg::DIM_W-1:0]   m_out_row,
    output logic [pe2x_pkg::DIM_W-1:0]   m_out_col,
    output logic                         m_last_of_run,
    output logic                         m_frame_done,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [pe2x_pkg::DIM_W-1:0]   cfg_data
);

    localparam int DW = pe2x_pkg::DIM_W;
    localparam int TW = pe2x_pkg::TAP_W;

    logic [DW-1:0]        width_reg, height_reg;
    logic [4:0][TW-1:0]   tap_reg;
    pe2x_pkg::cfg_t       cfg;

    logic                 fq_valid, fq_ready, qb_valid, qb_pop;
    pe2x_pkg::job_t       fq_job, qb_job;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(640);
            height_reg <= DW'(480);
            tap_reg    <= {TW'(32), TW'(128), TW'(192), TW'(128), TW'(32)};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pe2x_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                pe2x_pkg::REG_HEIGHT: height_reg <= cfg_data;
                pe2x_pkg::REG_TAP0:   tap_reg[0] <= cfg_data[TW-1:0];
                pe2x_pkg::REG_TAP1:   tap_reg[1] <= cfg_data[TW-1:0];
                pe2x_pkg::REG_TAP2:   tap_reg[2] <= cfg_data[TW-1:0];
                pe2x_pkg::REG_TAP3:   tap_reg[3] <= cfg_data[TW-1:0];
                pe2x_pkg::REG_TAP4:   tap_reg[4] <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // clamp size to supported range
    always_comb begin
        if (width_reg == '0)                 cfg.width = DW'(1);
        else if (32'(width_reg) > MAX_WIDTH) cfg.width = DW'(MAX_WIDTH);
        else                                 cfg.width = width_reg;
        if (height_reg == '0)                cfg.height = DW'(1);
        else if (height_reg > DW'(1024))     cfg.height = DW'(1024);
        else                                 cfg.height = height_reg;
        cfg.tap = tap_reg;
    end

    pe2x_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_pixel(s_pixel),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    pe2x_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push_valid(fq_valid), .push_ready(fq_ready), .push_job(fq_job),
        .pop_valid(qb_valid), .pop(qb_pop), .head(qb_job)
    );

    pe2x_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .job_valid(qb_valid), .job(qb_job), .job_pop(qb_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_out_row(m_out_row), .m_out_col(m_out_col),
        .m_last_of_run(m_last_of_run), .m_frame_done(m_frame_done)
    );

endmodule

>>> hw/rtl/pe2x_checker.sv
// ----------------------------------------------------------------------------
// pe2x_checker: port-level checks
// Output hold under stall and border properties of the expanded frame.
// ----------------------------------------------------------------------------
module pe2x_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_value,
    input logic [10:0] m_out_row,
    input logic        m_last_of_run,
    input logic        m_frame_done
);

    // a stalled item stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_out_row))
        else $error("output item changed while stalled");

    // frame end closes an item's run
    a_fd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_last_of_run)
        else $error("frame_done without last_of_run");

    // bottom-right corner is border
    a_fd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_value == 8'd0)
        else $error("corner pixel not zero");

    // top row is border
    a_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_row == 11'd0 |-> m_value == 8'd0)
        else $error("top row pixel not zero");

endmodule

bind pyramid_expand_2x pe2x_checker u_pe2x_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_value(m_value), .m_out_row(m_out_row), .m_last_of_run(m_last_of_run),
    .m_frame_done(m_frame_done)
);
